// ===== hdl/uqpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqpp_pkg
// Shared types, character codes, known keys and unit multipliers for the
// URL query parameter parser.
// ----------------------------------------------------------------------------
package uqpp_pkg;

  localparam int MAX_VALUE_BYTES_DEF = 64;
  localparam int MULT_W              = 43;
  localparam int NUM_KEYS            = 4;
  localparam int KEY_MAX_LEN         = 9;

  // Character codes.
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_U     = 8'h75;

  // Key codes.
  localparam logic [1:0] KEY_DB        = 2'd0;
  localparam logic [1:0] KEY_PRECISION = 2'd1;
  localparam logic [1:0] KEY_USER      = 2'd2;
  localparam logic [1:0] KEY_PASSWORD  = 2'd3;

  localparam logic [7:0] KEY_CHARS [NUM_KEYS][KEY_MAX_LEN] = '{
    '{8'h64, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h72, 8'h65, 8'h63, 8'h69, 8'h73, 8'h69, 8'h6F, 8'h6E},
    '{8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd2, 4'd9, 4'd1, 4'd1};

  // Nanoseconds per unit.
  localparam logic signed [MULT_W-1:0] MULT_NS      = 43'sd1;
  localparam logic signed [MULT_W-1:0] MULT_US      = 43'sd1000;
  localparam logic signed [MULT_W-1:0] MULT_MS      = 43'sd1000000;
  localparam logic signed [MULT_W-1:0] MULT_S       = 43'sd1000000000;
  localparam logic signed [MULT_W-1:0] MULT_MIN     = 43'sd60000000000;
  localparam logic signed [MULT_W-1:0] MULT_HOUR    = 43'sd3600000000000;
  localparam logic signed [MULT_W-1:0] MULT_UNKNOWN = '1;
  localparam logic signed [MULT_W-1:0] MULT_NONE    = '0;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic take;   // accept the input byte
    logic step;   // issue the next result into the output register
  } cmd_t;

  typedef struct packed {
    logic fin_go;     // the byte offered ends a parameter that has results
    logic last_step;  // the next result to be issued is the final one
    logic out_valid;  // the output register holds a result
  } stat_t;

  // Expected key character at a position, zero beyond the longest key.
  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < 4'(KEY_MAX_LEN)) begin
      ch = KEY_CHARS[k][pos];
    end
    return ch;
  endfunction

  function automatic logic signed [MULT_W-1:0] unit_mult(
    input logic       len_one,
    input logic       len_two,
    input logic [7:0] a,
    input logic [7:0] b,
    input logic       ovf
  );
    logic signed [MULT_W-1:0] m;
    m = MULT_UNKNOWN;
    if (!ovf) begin
      if (len_one) begin
        if (a == CH_S) begin
          m = MULT_S;
        end else if (a == CH_M) begin
          m = MULT_MIN;
        end else if (a == CH_H) begin
          m = MULT_HOUR;
        end
      end else if (len_two && b == CH_S) begin
        if (a == CH_N) begin
          m = MULT_NS;
        end else if (a == CH_U) begin
          m = MULT_US;
        end else if (a == CH_M) begin
          m = MULT_MS;
        end
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/uqpp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqpp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module uqpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/uqpp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqpp_ctrl
// Controller: takes bytes while idle and sequences the results of a
// finished parameter into the output register.
// ----------------------------------------------------------------------------
module uqpp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  input  uqpp_pkg::stat_t stat,
  output uqpp_pkg::cmd_t  cmd
);

  uqpp_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.step   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      uqpp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && stat.fin_go) begin
          state_next = uqpp_pkg::S_EMIT;
        end
      end
      uqpp_pkg::S_EMIT: begin
        // A new result goes in whenever the output register is free or being emptied.
        cmd.step = !stat.out_valid || out_ready;
        if (cmd.step && stat.last_step) begin
          state_next = uqpp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = uqpp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uqpp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/uqpp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqpp_dpath
// Datapath: key matching, value buffer, parameter bookkeeping and the
// output register.
// ----------------------------------------------------------------------------
module uqpp_dpath #(
  parameter int MAX_VALUE_BYTES = uqpp_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  uqpp_pkg::cmd_t                        cmd,
  output uqpp_pkg::stat_t                       stat,
  input  logic [7:0]                            data_byte,
  input  logic                                  first_byte,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [1:0]                            key_code,
  output logic [7:0]                            value_char,
  output logic                                  value_empty,
  output logic                                  value_truncated,
  output logic signed [uqpp_pkg::MULT_W-1:0]    time_multiplier,
  output logic                                  last_of_value
);

  localparam int LEN_W  = $clog2(MAX_VALUE_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_VALUE_BYTES);

  // Parameter scan state.
  logic             scan_active;
  logic             equals_seen;
  logic             key_invalid;
  logic [3:0]       key_match;
  logic [3:0]       key_length;
  logic [LEN_W-1:0] value_length;
  logic             value_overflow;
  logic [7:0]       byte0;
  logic [7:0]       byte1;

  // Emission of a finished parameter.
  logic [ADDR_W-1:0]                     emit_idx;
  logic [ADDR_W-1:0]                     emit_last_idx;
  logic                                  emit_empty;
  logic [1:0]                            emit_code;
  logic                                  emit_trunc;
  logic signed [uqpp_pkg::MULT_W-1:0]    emit_mult;

  logic [7:0] rdata;

  logic       is_end, is_amp, is_eq;
  logic       code_found;
  logic [1:0] code;
  logic [3:0] key_match_next;
  logic       store_byte;
  logic       last_issue;

  assign is_end = (data_byte == uqpp_pkg::CH_HASH) || (data_byte == uqpp_pkg::CH_SPACE);
  assign is_amp = (data_byte == uqpp_pkg::CH_AMP);
  assign is_eq  = (data_byte == uqpp_pkg::CH_EQ);

  always_comb begin
    code_found = 1'b0;
    code       = uqpp_pkg::KEY_DB;
    for (int i = 0; i < uqpp_pkg::NUM_KEYS; i++) begin
      if (key_match[i] && key_length == uqpp_pkg::KEY_LEN[i]) begin
        code_found = 1'b1;
        code       = 2'(i);
      end
    end
  end

  always_comb begin
    key_match_next = key_match;
    for (int i = 0; i < uqpp_pkg::NUM_KEYS; i++) begin
      if (key_length >= uqpp_pkg::KEY_LEN[i] ||
          uqpp_pkg::key_char(2'(i), key_length) != data_byte) begin
        key_match_next[i] = 1'b0;
      end
    end
  end

  assign stat.fin_go = scan_active && !first_byte && (is_end || is_amp) &&
                       equals_seen && !key_invalid && code_found;
  assign last_issue     = emit_empty || (emit_idx == emit_last_idx);
  assign stat.last_step = last_issue;
  assign stat.out_valid = out_valid;

  assign store_byte = cmd.take && !first_byte && scan_active && !is_end && !is_amp &&
                      !is_eq && equals_seen && (value_length < LEN_W'(MAX_VALUE_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active    <= 1'b0;
      equals_seen    <= 1'b0;
      key_invalid    <= 1'b0;
      key_match      <= 4'hF;
      key_length     <= 4'd0;
      value_length   <= '0;
      value_overflow <= 1'b0;
    end else if (cmd.take) begin
      if (first_byte || (scan_active && (is_end || is_amp))) begin
        equals_seen    <= 1'b0;
        key_invalid    <= 1'b0;
        key_match      <= 4'hF;
        key_length     <= 4'd0;
        value_length   <= '0;
        value_overflow <= 1'b0;
        if (first_byte) begin
          scan_active <= (data_byte == uqpp_pkg::CH_QMARK);
        end else if (is_end) begin
          scan_active <= 1'b0;
        end
      end else if (scan_active) begin
        if (is_eq) begin
          if (equals_seen) begin
            key_invalid <= 1'b1;
          end else begin
            equals_seen    <= 1'b1;
            value_length   <= '0;
            value_overflow <= 1'b0;
          end
        end else if (!equals_seen) begin
          key_match <= key_match_next;
          if (key_length != 4'hF) begin
            key_length <= key_length + 4'd1;
          end
        end else if (value_length < LEN_W'(MAX_VALUE_BYTES)) begin
          value_length <= value_length + LEN_W'(1);
        end else begin
          value_overflow <= 1'b1;
        end
      end
    end
  end

  // First two value bytes are kept aside for the unit lookup.
  always_ff @(posedge clk) begin
    if (store_byte && value_length == LEN_W'(0)) begin
      byte0 <= data_byte;
    end
    if (store_byte && value_length == LEN_W'(1)) begin
      byte1 <= data_byte;
    end
  end

  // Parameter snapshot taken when a parameter with results ends.
  always_ff @(posedge clk) begin
    if (cmd.take && stat.fin_go) begin
      emit_code     <= code;
      emit_trunc    <= value_overflow;
      emit_empty    <= (value_length == LEN_W'(0));
      emit_last_idx <= ADDR_W'(value_length - LEN_W'(1));
      emit_idx      <= '0;
      if (code == uqpp_pkg::KEY_PRECISION) begin
        emit_mult <= uqpp_pkg::unit_mult(value_length == LEN_W'(1),
                                         value_length == LEN_W'(2),
                                         byte0, byte1, value_overflow);
      end else begin
        emit_mult <= uqpp_pkg::MULT_NONE;
      end
    end else if (cmd.step) begin
      emit_idx <= emit_idx + ADDR_W'(1);
    end
  end

  uqpp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_VALUE_BYTES)
  ) u_value_ram (
    .clk   (clk),
    .we    (store_byte),
    .waddr (value_length[ADDR_W-1:0]),
    .wdata (data_byte),
    .re    (cmd.step && !emit_empty),
    .raddr (emit_idx),
    .rdata (rdata)
  );

  // Output register; the value byte itself sits in the RAM's read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      key_code        <= emit_code;
      value_empty     <= emit_empty;
      value_truncated <= emit_trunc;
      time_multiplier <= emit_mult;
      last_of_value   <= last_issue;
    end
  end

  assign value_char = value_empty ? 8'h00 : rdata;

endmodule

// ===== hdl/url_query_param_parser_unit.sv =====
`timescale 1ns / 1ps
// The first result of a parameter passes from the snapshot, taken when the '&', '#' or space
// that ends it is accepted, to the output register; further results follow one per cycle
// while out_ready is high. Input: one byte per cycle while idle; it stalls while a value is
// emitted, one result per value byte (one for an empty value), via the single buffer read port.
// Reset (synchronous, rst high) clears the scan and handshake state; the value
// buffer is not cleared, as only bytes written for the current value are read.
// ----------------------------------------------------------------------------
// url_query_param_parser_unit
// Scans URL query bytes and emits the values of the recognised keys.
// ----------------------------------------------------------------------------
module url_query_param_parser_unit #(
  parameter int MAX_VALUE_BYTES = uqpp_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            data_byte,
  input  logic                                  first_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            key_code,
  output logic [7:0]                            value_char,
  output logic                                  value_empty,
  output logic                                  value_truncated,
  output logic signed [uqpp_pkg::MULT_W-1:0]    time_multiplier,
  output logic                                  last_of_value
);

  uqpp_pkg::cmd_t  cmd;
  uqpp_pkg::stat_t stat;

  uqpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uqpp_dpath #(
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .data_byte       (data_byte),
    .first_byte      (first_byte),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .key_code        (key_code),
    .value_char      (value_char),
    .value_empty     (value_empty),
    .value_truncated (value_truncated),
    .time_multiplier (time_multiplier),
    .last_of_value   (last_of_value)
  );

endmodule

// ===== hdl/uqpp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uqpp_checker
// Port-level checks on the URL query parameter parser, bound to the top level.
// ----------------------------------------------------------------------------
module uqpp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [1:0]                            key_code,
  input logic [7:0]                            value_char,
  input logic                                  value_empty,
  input logic                                  last_of_value,
  input logic signed [uqpp_pkg::MULT_W-1:0]    time_multiplier
);

  // A stalled item keeps its value byte.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_char) && $stable(last_of_value))
    else $error("output item changed while stalled");

  // Results of one value come back to back.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_value |=> out_valid)
    else $error("gap inside a value");

  // Input waits while a value is still being emitted.
  a_no_input_mid_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_value |-> !in_ready)
    else $error("input taken in the middle of a value");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_empty |-> last_of_value && value_char == 8'h00)
    else $error("malformed empty marker");

  a_mult_other_keys: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_code != uqpp_pkg::KEY_PRECISION |-> time_multiplier == uqpp_pkg::MULT_NONE)
    else $error("multiplier on a key other than precision");

endmodule

bind url_query_param_parser_unit uqpp_checker u_uqpp_checker (.*);

// ===== tb/url_query_param_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_query_param_parser_unit_tb
// Feeds query bytes through the parser under varying back-pressure. A
// behavioural scanner predicts every emitted value byte, and each result
// leaving the block is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module url_query_param_parser_unit_tb;
  import uqpp_pkg::*;

  localparam int VALUE_DEPTH  = MAX_VALUE_BYTES_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 28;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0]        key;
    logic [7:0]        ch;
    logic              empty;
    logic              cut;
    logic [MULT_W-1:0] mult;
    logic              last;
  } value_rec_t;

  typedef struct packed {
    logic [7:0] c;
    logic       f;
    logic       typed;
    value_rec_t res;
  } stim_row_t;

  localparam value_rec_t NO_RESULT  = '0;
  localparam value_rec_t USER_EMPTY = '{KEY_USER, 8'h00, 1'b1, 1'b0, MULT_NONE, 1'b1};

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               data_byte;
  logic                     first_byte;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               key_code;
  logic [7:0]               value_char;
  logic                     value_empty;
  logic                     value_truncated;
  logic signed [MULT_W-1:0] time_multiplier;
  logic                     last_of_value;

  // Scanner state mirrored from the block.
  logic       in_query;
  logic       after_eq;
  logic       key_broken;
  logic [3:0] key_hits;
  logic [3:0] key_count;
  logic [7:0] val_bytes [VALUE_DEPTH];
  logic [6:0] val_count;
  logic       val_cut;

  value_rec_t value_q [$];
  string      key_names [NUM_KEYS] = '{"db", "precision", "u", "p"};

  logic       row_typed = 1'b0;
  value_rec_t row_result = '0;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         bytes_sent = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         holds_asked = 0;
  int         holds_done = 0;

  // Directed items; only the rows whose result is obvious carry it typed in.
  stim_row_t dir_rows [28] = '{
    '{CH_QMARK, 1'b1, 1'b0, NO_RESULT},
    '{"u",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_AMP,   1'b0, 1'b1, USER_EMPTY},
    '{"p",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{8'hFF,    1'b0, 1'b0, NO_RESULT},
    '{8'h00,    1'b0, 1'b0, NO_RESULT},
    '{CH_AMP,   1'b0, 1'b0, NO_RESULT},
    '{"u",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_AMP,   1'b0, 1'b0, NO_RESULT},
    '{"d",      1'b0, 1'b0, NO_RESULT},
    '{"b",      1'b0, 1'b0, NO_RESULT},
    '{CH_AMP,   1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_SPACE, 1'b0, 1'b0, NO_RESULT},
    '{"u",      1'b0, 1'b0, NO_RESULT},
    '{8'h00,    1'b1, 1'b0, NO_RESULT},
    '{CH_HASH,  1'b0, 1'b0, NO_RESULT},
    '{CH_QMARK, 1'b1, 1'b0, NO_RESULT},
    '{"u",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_QMARK, 1'b1, 1'b0, NO_RESULT},
    '{"u",      1'b0, 1'b0, NO_RESULT},
    '{CH_EQ,    1'b0, 1'b0, NO_RESULT},
    '{CH_SPACE, 1'b0, 1'b1, USER_EMPTY}
  };

  url_query_param_parser_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .first_byte      (first_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .key_code        (key_code),
    .value_char      (value_char),
    .value_empty     (value_empty),
    .value_truncated (value_truncated),
    .time_multiplier (time_multiplier),
    .last_of_value   (last_of_value)
  );

  always #1 clk = ~clk;

  function void start_param();
    after_eq   = 1'b0;
    key_broken = 1'b0;
    key_hits   = 4'hF;
    key_count  = 4'd0;
    val_count  = 7'd0;
    val_cut    = 1'b0;
  endfunction

  function logic [MULT_W-1:0] precision_mult();
    logic [MULT_W-1:0] m;
    m = MULT_UNKNOWN;
    if (!val_cut) begin
      if (val_count == 7'd1) begin
        if (val_bytes[0] == CH_S) begin
          m = MULT_S;
        end else if (val_bytes[0] == CH_M) begin
          m = MULT_MIN;
        end else if (val_bytes[0] == CH_H) begin
          m = MULT_HOUR;
        end
      end else if (val_count == 7'd2 && val_bytes[1] == CH_S) begin
        if (val_bytes[0] == CH_N) begin
          m = MULT_NS;
        end else if (val_bytes[0] == CH_U) begin
          m = MULT_US;
        end else if (val_bytes[0] == CH_M) begin
          m = MULT_MS;
        end
      end
    end
    return m;
  endfunction

  // A parameter has ended: queue its value bytes if the key is one we know.
  task automatic close_param();
    int         code;
    int         i;
    value_rec_t r;
    code = -1;
    if (after_eq && !key_broken) begin
      for (i = 0; i < NUM_KEYS; i++) begin
        if (key_hits[i] && key_count == key_names[i].len()) begin
          code = i;
        end
      end
    end
    if (code >= 0) begin
      r.key  = 2'(code);
      r.cut  = val_cut;
      r.mult = (code == KEY_PRECISION) ? precision_mult() : MULT_NONE;
      if (val_count == 7'd0) begin
        r.ch    = 8'h00;
        r.empty = 1'b1;
        r.last  = 1'b1;
        value_q.push_back(r);
      end else begin
        for (i = 0; i < val_count; i++) begin
          r.ch    = val_bytes[i];
          r.empty = 1'b0;
          r.last  = (i == val_count - 1);
          value_q.push_back(r);
        end
      end
    end
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic f);
    int i;
    if (f) begin
      start_param();
      in_query = (c == CH_QMARK);
    end else if (in_query) begin
      if (c == CH_HASH || c == CH_SPACE) begin
        close_param();
        start_param();
        in_query = 1'b0;
      end else if (c == CH_AMP) begin
        close_param();
        start_param();
      end else if (c == CH_EQ) begin
        if (after_eq) begin
          key_broken = 1'b1;
        end else begin
          after_eq  = 1'b1;
          val_count = 7'd0;
          val_cut   = 1'b0;
        end
      end else if (!after_eq) begin
        for (i = 0; i < NUM_KEYS; i++) begin
          if (key_count >= key_names[i].len() || key_names[i][key_count] != c) begin
            key_hits[i] = 1'b0;
          end
        end
        if (key_count != 4'hF) begin
          key_count = key_count + 4'd1;
        end
      end else if (val_count < VALUE_DEPTH) begin
        val_bytes[val_count[5:0]] = c;
        val_count = val_count + 7'd1;
      end else begin
        val_cut = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Results are checked before the byte of the same edge is scanned; no byte
  // can produce a result in the cycle it is accepted.
  always @(posedge clk) begin : monitor
    int         depth;
    value_rec_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (value_q.size() == 0) begin
          errors++;
          $display("%0t: result expected none, actual key %0d char %02h last %0b",
                   $time, key_code, value_char, last_of_value);
        end else begin
          want = value_q.pop_front();
          check_field("key_code", want.key, key_code);
          check_field("value_char", want.ch, value_char);
          check_field("value_empty", want.empty, value_empty);
          check_field("value_truncated", want.cut, value_truncated);
          check_field("time_multiplier", $signed(want.mult), time_multiplier);
          check_field("last_of_value", want.last, last_of_value);
        end
      end
      if (in_valid && in_ready) begin
        depth = value_q.size();
        scan_byte(data_byte, first_byte);
        if (row_typed) begin
          while (value_q.size() > depth) begin
            void'(value_q.pop_back());
          end
          value_q.push_back(row_result);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin : receiver
    int k;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Entered and left at a falling edge; valid is left high for the caller.
  task automatic send_byte(input logic [7:0] c, input logic f);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= c;
    first_byte <= f;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  // Mostly plain value characters; now and then any byte at all.
  function automatic logic [7:0] value_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ($urandom_range(19) != 0) begin
      while (c == CH_AMP || c == CH_HASH || c == CH_SPACE || c == CH_EQ) begin
        c = 8'($urandom_range(255));
      end
    end
    return c;
  endfunction

  task automatic send_param();
    int pick;
    int n;
    int i;
    pick = $urandom_range(9);
    case (pick)
      0, 1:    send_text("db");
      2, 3, 4: send_text("precision");
      5:       send_text("u");
      6:       send_text("p");
      7:       send_text("pre");
      8: begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(97, 122)), 1'b0);
        end
      end
      default: ;
    endcase
    if ($urandom_range(9) != 0) begin
      send_byte(CH_EQ, 1'b0);
    end
    if ($urandom_range(19) == 0) begin
      send_byte(CH_EQ, 1'b0);
    end
    if (pick >= 2 && pick <= 4 && $urandom_range(3) != 0) begin
      case ($urandom_range(7))
        0:       send_text("ns");
        1:       send_text("us");
        2:       send_text("ms");
        3:       send_text("s");
        4:       send_text("m");
        5:       send_text("h");
        6:       send_text("hs");
        default: ;
      endcase
    end else begin
      n = ($urandom_range(29) == 0) ? $urandom_range(7, 70) : $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        send_byte(value_byte(), 1'b0);
      end
    end
  endtask

  task automatic send_query();
    int n;
    int i;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(4) == 0));
      end
    end else begin
      send_byte(($urandom_range(11) == 0) ? value_byte() : CH_QMARK, 1'b1);
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        if (i != 0) begin
          send_byte(CH_AMP, 1'b0);
        end
        send_param();
      end
      case ($urandom_range(9))
        0, 1, 2, 3: send_byte(CH_HASH, 1'b0);
        4, 5, 6, 7: send_byte(CH_SPACE, 1'b0);
        8: begin
          send_byte(CH_AMP, 1'b0);
          send_byte(CH_HASH, 1'b0);
        end
        default: ;
      endcase
      if ($urandom_range(4) == 0) begin
        send_byte(value_byte(), 1'b0);
      end
    end
  endtask

  task automatic drain_values();
    in_valid <= 1'b0;
    while (value_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int i;
    int ph;
    int target;
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    first_byte = 1'b0;
    in_query   = 1'b0;
    start_param();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(dir_rows); i++) begin
      row_typed  = dir_rows[i].typed;
      row_result = dir_rows[i].res;
      send_byte(dir_rows[i].c, dir_rows[i].f);
      row_typed = 1'b0;
    end

    // A precision value cut at the buffer size, then a value that just fits.
    send_byte(CH_QMARK, 1'b1);
    send_text("precision=");
    for (i = 0; i < VALUE_DEPTH + 1; i++) begin
      send_byte(value_byte(), 1'b0);
    end
    send_byte(CH_HASH, 1'b0);
    send_byte(CH_QMARK, 1'b1);
    send_text("u=");
    for (i = 0; i < VALUE_DEPTH; i++) begin
      send_byte(value_byte(), 1'b0);
    end
    send_byte(CH_SPACE, 1'b0);

    // The receiver holds off while several parameters keep arriving.
    holds_asked++;
    send_byte(CH_QMARK, 1'b1);
    send_text("db=abcd&u=xy&p=&precision=ms#");
    drain_values();

    for (ph = 0; ph < 4; ph++) begin
      send_gap_pct   = (ph == 1) ? 52 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 36 : 0;
      target = bytes_sent + RANDOM_ITEMS / 4;
      while (bytes_sent < target) begin
        send_query();
      end
      drain_values();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && value_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/uqpp_pkg.sv
hdl/uqpp_ram.sv
hdl/uqpp_ctrl.sv
hdl/uqpp_dpath.sv
hdl/url_query_param_parser_unit.sv
hdl/uqpp_checker.sv
tb/url_query_param_parser_unit_tb.sv
